// ===== src/cdi8_pkg.sv =====
// Shared types, codes and constants for the checked decimal to int8 parser.
package cdi8_pkg;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;

  localparam logic [7:0] LIMIT_POS = 8'd127;
  localparam logic [7:0] LIMIT_NEG = 8'd128;

  localparam logic [1:0] KEPT_MAX = 2'd3;

  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_PLUS  = 2'd1,
    SIGN_MINUS = 2'd2
  } sign_mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NAN     = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Running parse state of one string.
  typedef struct packed {
    logic [1:0] kept_count;
    sign_mode_t sign_mode;
    logic [7:0] magnitude;
    logic       leading_zero_seen;
    logic       range_error;
    logic       bad_char_seen;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    kept_count:        2'd0,
    sign_mode:         SIGN_NONE,
    magnitude:         8'd0,
    leading_zero_seen: 1'b0,
    range_error:       1'b0,
    bad_char_seen:     1'b0
  };

endpackage

// ===== src/cdi8_in_if.sv =====
// Request channel: one character of the string, or an end mark, per request.
interface cdi8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_present;
  logic       last;

  modport source (output valid, output char_code, output char_present, output last,
                  input ready);
  modport sink (input valid, input char_code, input char_present, input last,
                output ready);
endinterface

// ===== src/cdi8_out_if.sv =====
// Result channel: parsed value and status, one per string.
interface cdi8_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] value;
  logic [1:0]        status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

// ===== src/checked_decimal_to_int8.sv =====
// Top level: streaming range-checked decimal string to signed 8-bit parser.
//
//  channel | dir | fields                          | one request is
//  --------+-----+---------------------------------+---------------------------
//  din     | in  | char_code, char_present, last   | one character or end mark
//  dout    | out | value, status                   | one parsed string
//
// Steps: a request is registered, then combinational update logic (x10 + digit
// and compare against 127/128) folds it into the parse state; a string's result
// is written to the output register when its last request leaves the input register.
// Throughput is one request per cycle while no request carrying last is stalled.
// Reset (rst, synchronous) clears the parse state and both valid flags.
// Stalls: only a request carrying last waits on a full, unaccepted result slot;
// din.ready drops only when that request is blocked in the input register.
module checked_decimal_to_int8 (
  input logic        clk,
  input logic        rst,
  cdi8_in_if.sink    din,
  cdi8_out_if.source dout
);
  import cdi8_pkg::*;

  // input register
  logic       in_q_valid;
  logic [7:0] in_q_char;
  logic       in_q_present;
  logic       in_q_last;

  // parse state of the string in progress
  parse_state_t st;
  parse_state_t st_upd;

  // result register
  logic              out_valid;
  logic signed [7:0] out_value;
  status_t           out_status;

  logic    slot_free;
  logic    adv;
  logic    din_fire;
  logic    is_nan;
  logic    is_invalid;
  status_t res_status;
  logic [7:0] res_value;

  assign slot_free = !out_valid || dout.ready;
  // the registered request is consumed unless it ends a string and the slot is full
  assign adv       = in_q_valid && (!in_q_last || slot_free);
  assign din.ready = !in_q_valid || adv;
  assign din_fire  = din.valid && din.ready;

  cdi8_char_update u_upd (
    .st           (st),
    .char_code    (in_q_char),
    .char_present (in_q_present),
    .st_next      (st_upd)
  );

  // Final classification; not-a-number wins over invalid.
  assign is_nan = (st_upd.kept_count == 2'd0) || st_upd.bad_char_seen ||
                  ((st_upd.kept_count == 2'd1) && (st_upd.sign_mode != SIGN_NONE));
  assign is_invalid = (st_upd.leading_zero_seen &&
                       ((st_upd.sign_mode != SIGN_NONE) || (st_upd.kept_count >= 2'd2))) ||
                      st_upd.range_error;

  always_comb begin
    res_value = 8'd0;
    priority if (is_nan) begin
      res_status = ST_NAN;
    end else if (is_invalid) begin
      res_status = ST_INVALID;
    end else begin
      res_status = ST_OK;
      res_value  = (st_upd.sign_mode == SIGN_MINUS) ? 8'(8'd0 - st_upd.magnitude)
                                                    : st_upd.magnitude;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (din.ready) begin
      in_q_valid <= din.valid;
    end
    if (din_fire) begin
      in_q_char    <= din.char_code;
      in_q_present <= din.char_present;
      in_q_last    <= din.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PARSE_RESET;
    end else if (adv) begin
      st <= in_q_last ? PARSE_RESET : st_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && in_q_last) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
    if (adv && in_q_last) begin
      out_value  <= signed'(res_value);
      out_status <= res_status;
    end
  end

  assign dout.valid  = out_valid;
  assign dout.value  = out_value;
  assign dout.status = out_status;

  // error results always carry zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> (out_value == 8'sd0))
    else $error("error result with nonzero value");

  // the end of a string returns the parser to its clean state
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (adv && in_q_last) |=> (st == PARSE_RESET))
    else $error("parse state not cleared after end of string");

  // a blocked request stays in the input register
  a_hold_blocked: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !adv) |=> (in_q_valid && $stable(in_q_char) && $stable(in_q_last)))
    else $error("blocked request lost");

  // nothing kept means nothing accumulated
  a_empty_state: assert property (@(posedge clk) disable iff (rst)
    (st.kept_count == 2'd0) |-> ((st.magnitude == 8'd0) && (st.sign_mode == SIGN_NONE)))
    else $error("state changed without a kept character");

  // a full, stalled result slot is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !dout.ready) |-> !(adv && in_q_last))
    else $error("result overwritten while stalled");

endmodule

// ===== src/cdi8_char_update.sv =====
// Next parse state after one character (digit accumulate, sign and error flags).
module cdi8_char_update (
  input  cdi8_pkg::parse_state_t st,
  input  logic [7:0]             char_code,
  input  logic                   char_present,
  output cdi8_pkg::parse_state_t st_next
);
  import cdi8_pkg::*;

  logic        kept;
  logic        is_digit;
  logic        is_sign;
  logic [3:0]  digit;
  logic        first_digit;
  logic [11:0] accum;
  logic [7:0]  limit;

  assign kept        = char_present && (char_code != CH_SPACE);
  assign is_digit    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_sign     = (char_code == CH_PLUS) || (char_code == CH_MINUS);
  assign digit       = 4'(char_code - CH_ZERO);
  assign first_digit = (st.kept_count == 2'd0) ||
                       ((st.kept_count == 2'd1) && (st.sign_mode != SIGN_NONE));
  // magnitude * 10 + digit as two shifts and an add
  assign accum = {1'b0, st.magnitude, 3'b000} + {3'b000, st.magnitude, 1'b0}
               + {8'd0, digit};
  assign limit = (st.sign_mode == SIGN_MINUS) ? LIMIT_NEG : LIMIT_POS;

  always_comb begin
    st_next = st;
    if (kept) begin
      if (is_digit) begin
        if (first_digit && (digit == 4'd0)) begin
          st_next.leading_zero_seen = 1'b1;
        end
        if (!st.range_error) begin
          if (accum > {4'd0, limit}) begin
            st_next.range_error = 1'b1;
          end else begin
            st_next.magnitude = accum[7:0];
          end
        end
      end else if (is_sign && (st.kept_count == 2'd0)) begin
        st_next.sign_mode = (char_code == CH_PLUS) ? SIGN_PLUS : SIGN_MINUS;
      end else begin
        st_next.bad_char_seen = 1'b1;
      end
      if (st.kept_count != KEPT_MAX) begin
        st_next.kept_count = st.kept_count + 2'd1;
      end
    end
  end

endmodule
